// ===== design/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// shared types and constants of the sha-256 digest engine
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int WORD_W    = 32;
   localparam int ROUNDS    = 64;
   localparam int SCHED_LEN = 16;
   localparam int HASH_LEN  = 8;

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [WORD_W-1:0] INIT_HASH [HASH_LEN] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] PAD_WORD    = 32'h8000_0000;
   localparam logic [2:0]        PAD_BYTES   = 3'd1;
   localparam logic [2:0]        WORD_BYTES  = 3'd4;
   localparam logic [5:0]        LEN_OFFSET  = 6'd56;
   localparam logic [3:0]        LEN_HI_IDX  = 4'd14;
   localparam logic [3:0]        LEN_LO_IDX  = 4'd15;
   localparam logic [2:0]        LAST_INDEX  = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ZERO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_HASH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic              init;
      logic              wr_en;
      logic [3:0]        wr_index;
      logic [WORD_W-1:0] wr_data;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

endpackage

// ===== design/sha256_req_if.sv =====
// ----------------------------------------------------------------------------
// sha256_req_if
// message word channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface sha256_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        final_word;

   modport source (output valid, message_word, valid_bytes, final_word, input ready);
   modport sink   (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

// ===== design/sha256_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sha256_rsp_if
// digest word channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sha256_core.sv =====
// ----------------------------------------------------------------------------
// sha256_core
// compression unit: one round per cycle over a 16-word schedule window,
// then a fold of the working variables into the chaining value
// ----------------------------------------------------------------------------
module sha256_core (
   input  logic                                           clock,
   input  logic                                           reset,
   input  sha256_pkg::core_ctl_type                       ctl,
   output sha256_pkg::core_sts_type                       sts,
   output logic [sha256_pkg::HASH_LEN-1:0][sha256_pkg::WORD_W-1:0] hash_value
);

   logic [sha256_pkg::WORD_W-1:0] chain_ff [sha256_pkg::HASH_LEN];
   logic [sha256_pkg::WORD_W-1:0] chain_in [sha256_pkg::HASH_LEN];
   logic [sha256_pkg::WORD_W-1:0] work_ff  [sha256_pkg::HASH_LEN];
   logic [sha256_pkg::WORD_W-1:0] work_in  [sha256_pkg::HASH_LEN];
   logic [sha256_pkg::WORD_W-1:0] sched_ff [sha256_pkg::SCHED_LEN];
   logic [sha256_pkg::WORD_W-1:0] sched_in [sha256_pkg::SCHED_LEN];
   logic [5:0]                    round_ff, round_in;
   logic                          busy_ff, busy_in;
   logic                          fold_ff, fold_in;

   logic [31:0] s0, s1, new_w, big0, big1, choose, major, t1, t2;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

   always_comb begin
      s0     = ror(sched_ff[1], 7) ^ ror(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
      s1     = ror(sched_ff[14], 17) ^ ror(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
      new_w  = sched_ff[0] + s0 + sched_ff[9] + s1;
      big1   = ror(work_ff[4], 6) ^ ror(work_ff[4], 11) ^ ror(work_ff[4], 25);
      choose = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1     = work_ff[7] + big1 + choose + sha256_pkg::ROUND_K[round_ff] + sched_ff[0];
      big0   = ror(work_ff[0], 2) ^ ror(work_ff[0], 13) ^ ror(work_ff[0], 22);
      major  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
               ^ (work_ff[1] & work_ff[2]);
      t2     = big0 + major;

      busy_in  = busy_ff;
      fold_in  = 1'b0;
      round_in = round_ff;
      chain_in = chain_ff;
      work_in  = work_ff;
      sched_in = sched_ff;

      if (ctl.wr_en) begin
         sched_in[ctl.wr_index] = ctl.wr_data;
      end
      if (ctl.start) begin
         busy_in  = 1'b1;
         round_in = '0;
         work_in  = chain_ff;
      end
      if (busy_ff) begin
         for (int i = 0; i < sha256_pkg::SCHED_LEN - 1; i++) begin
            sched_in[i] = sched_ff[i+1];
         end
         sched_in[sha256_pkg::SCHED_LEN-1] = new_w;
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
         round_in   = round_ff + 6'd1;
         if (round_ff == 6'(sha256_pkg::ROUNDS - 1)) begin
            busy_in = 1'b0;
            fold_in = 1'b1;
         end
      end
      if (fold_ff) begin
         for (int i = 0; i < sha256_pkg::HASH_LEN; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (ctl.init) begin
         chain_in = sha256_pkg::INIT_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fold_ff  <= 1'b0;
         round_ff <= '0;
         chain_ff <= sha256_pkg::INIT_HASH;
      end else begin
         busy_ff  <= busy_in;
         fold_ff  <= fold_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   always_comb begin
      for (int i = 0; i < sha256_pkg::HASH_LEN; i++) begin
         hash_value[i] = chain_ff[i];
      end
   end

   assign sts.busy = busy_ff | fold_ff;
   assign sts.done = fold_ff;

endmodule

// ===== design/sha256_message_digest.sv =====
// ----------------------------------------------------------------------------
// sha256_message_digest
// streaming sha-256 engine: packs message bytes, pads, hashes, emits digest
// ----------------------------------------------------------------------------
// Message words are taken one at a time (ready only while idle) and their
// valid leading bytes are packed into the 64-byte block at byte granularity.
// A word that completes a block starts the compression unit, which runs one
// round per cycle: 64 rounds and then a fold into the chaining value; no
// further word is accepted until the compression is done. The final word
// adds padding and length insertion, one or two compressions, and then
// eight digest words, index 0 first, one per accepted cycle. After the
// eighth word the engine returns to its reset state for the next message.
module sha256_message_digest (
   input  logic         clock,
   input  logic         reset,
   sha256_req_if.sink   req_if,
   sha256_rsp_if.source rsp_if
);

   sha256_pkg::state_type state_ff, state_in;
   sha256_pkg::state_type ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] partial_ff, partial_in;
   logic [60:0] total_ff, total_in;
   logic [2:0]  idx_ff, idx_in;

   sha256_pkg::core_ctl_type core_ctl;
   sha256_pkg::core_sts_type core_sts;
   logic [sha256_pkg::HASH_LEN-1:0][sha256_pkg::WORD_W-1:0] hash_value;

   logic [31:0] abs_data, abs_mask;
   logic [2:0]  abs_cnt, req_cnt;
   logic [63:0] merged;
   logic [6:0]  fill_sum, fill_up;
   logic        word_done;
   logic [63:0] bit_len;

   sha256_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (core_ctl),
      .sts        (core_sts),
      .hash_value (hash_value)
   );

   always_comb begin
      req_cnt   = (req_if.valid_bytes > sha256_pkg::WORD_BYTES) ?
                  sha256_pkg::WORD_BYTES : req_if.valid_bytes;
      abs_data  = (state_ff == sha256_pkg::ST_PAD) ? sha256_pkg::PAD_WORD
                                                  : req_if.message_word;
      abs_cnt   = (state_ff == sha256_pkg::ST_PAD) ? sha256_pkg::PAD_BYTES : req_cnt;
      abs_mask  = ~(32'hFFFF_FFFF >> {abs_cnt, 3'b000});
      merged    = {partial_ff, 32'h0} | ({abs_data & abs_mask, 32'h0} >> {fill_ff[1:0], 3'b000});
      fill_sum  = {1'b0, fill_ff} + {4'b0000, abs_cnt};
      word_done = ({1'b0, fill_ff[1:0]} + abs_cnt) >= sha256_pkg::WORD_BYTES;
      fill_up   = {1'b0, fill_ff[5:2], 2'b00} + 7'd4;
      bit_len   = {total_ff, 3'b000};

      state_in   = state_ff;
      ret_in     = ret_ff;
      fill_in    = fill_ff;
      partial_in = partial_ff;
      total_in   = total_ff;
      idx_in     = idx_ff;
      core_ctl   = '0;

      req_if.ready       = (state_ff == sha256_pkg::ST_IDLE);
      rsp_if.valid       = (state_ff == sha256_pkg::ST_OUT);
      rsp_if.digest_word = hash_value[idx_ff];
      rsp_if.word_index  = idx_ff;
      rsp_if.last_word   = (idx_ff == sha256_pkg::LAST_INDEX);

      unique case (state_ff)
         sha256_pkg::ST_IDLE, sha256_pkg::ST_PAD: begin
            if (state_ff == sha256_pkg::ST_PAD || req_if.valid) begin
               if (word_done) begin
                  core_ctl.wr_en    = 1'b1;
                  core_ctl.wr_index = fill_ff[5:2];
                  core_ctl.wr_data  = merged[63:32];
                  partial_in        = merged[31:0];
               end else begin
                  partial_in = merged[63:32];
               end
               fill_in = fill_sum[5:0];
               if (state_ff == sha256_pkg::ST_PAD) begin
                  ret_in = sha256_pkg::ST_ZERO;
               end else begin
                  total_in = total_ff + {58'd0, req_cnt};
                  ret_in   = req_if.final_word ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
               end
               if (fill_sum[6]) begin
                  core_ctl.start = 1'b1;
                  state_in       = sha256_pkg::ST_HASH;
               end else begin
                  state_in = ret_in;
               end
            end
         end
         sha256_pkg::ST_ZERO: begin
            if (fill_ff == sha256_pkg::LEN_OFFSET) begin
               state_in = sha256_pkg::ST_LEN_HI;
            end else begin
               core_ctl.wr_en    = 1'b1;
               core_ctl.wr_index = fill_ff[5:2];
               core_ctl.wr_data  = partial_ff;
               partial_in        = '0;
               fill_in           = fill_up[5:0];
               if (fill_up[6]) begin
                  core_ctl.start = 1'b1;
                  ret_in         = sha256_pkg::ST_ZERO;
                  state_in       = sha256_pkg::ST_HASH;
               end
            end
         end
         sha256_pkg::ST_LEN_HI: begin
            core_ctl.wr_en    = 1'b1;
            core_ctl.wr_index = sha256_pkg::LEN_HI_IDX;
            core_ctl.wr_data  = bit_len[63:32];
            state_in          = sha256_pkg::ST_LEN_LO;
         end
         sha256_pkg::ST_LEN_LO: begin
            core_ctl.wr_en    = 1'b1;
            core_ctl.wr_index = sha256_pkg::LEN_LO_IDX;
            core_ctl.wr_data  = bit_len[31:0];
            core_ctl.start    = 1'b1;
            fill_in           = '0;
            ret_in            = sha256_pkg::ST_OUT;
            state_in          = sha256_pkg::ST_HASH;
         end
         sha256_pkg::ST_HASH: begin
            if (core_sts.done) begin
               state_in = ret_ff;
            end
         end
         sha256_pkg::ST_OUT: begin
            if (rsp_if.ready) begin
               if (idx_ff == sha256_pkg::LAST_INDEX) begin
                  core_ctl.init = 1'b1;
                  total_in      = '0;
                  partial_in    = '0;
                  fill_in       = '0;
                  idx_in        = '0;
                  state_in      = sha256_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha256_pkg::ST_IDLE;
         ret_ff     <= sha256_pkg::ST_IDLE;
         fill_ff    <= '0;
         partial_ff <= '0;
         total_ff   <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         fill_ff    <= fill_in;
         partial_ff <= partial_in;
         total_ff   <= total_in;
         idx_ff     <= idx_in;
      end
   end

   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      core_sts.done |-> state_ff == sha256_pkg::ST_HASH)
      else $error("compression finished outside hash state");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      core_ctl.wr_en |-> !core_sts.busy)
      else $error("schedule written during compression");

   a_out_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (fill_ff == '0 && partial_ff == '0))
      else $error("digest out with block bytes pending");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_word)
      |=> (total_ff == '0 && state_ff == sha256_pkg::ST_IDLE))
      else $error("engine did not restart after last digest item");

endmodule
